// ----- design/vtlp_pkg.sv -----
// Package for the vertical takeoff/landing profile generator.
// Holds codes, constants, shared types and the saturation helper.
// No dependencies.
package vtlp_pkg;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_TAKEOFF = 2'd1;
  localparam logic [1:0] OP_LAND    = 2'd2;

  localparam logic CFG_STEP_TIME = 1'b0;
  localparam logic CFG_ACCEL     = 1'b1;

  localparam logic [15:0] STEP_TIME_RST = 16'd1311;
  localparam logic [15:0] ACCEL_RST     = 16'd6554;

  localparam logic [9:0]  HOLD_SAMPLES = 10'd100;
  localparam logic [19:0] MAX_SAMPLES  = 20'hFFFFF;
  localparam logic [63:0] LAND_FLOOR   = 64'hFFFF_FFFF_FF9C_0000;

  // Iteration counts of the shared unit.
  localparam logic [6:0] DIV_STEPS  = 7'd64;
  localparam logic [6:0] SQRT_STEPS = 7'd32;

  typedef enum logic [1:0] {
    IOP_MUL  = 2'd0,
    IOP_DIV  = 2'd1,
    IOP_SQRT = 2'd2
  } iop_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_UP   = 2'd1,
    MODE_DOWN = 2'd2
  } mode_t;

  typedef struct packed {
    logic       go;
    iop_t       op;
    logic [6:0] nbits;
  } req_t;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    logic signed [63:0] s;
    s = signed'(v);
    if (s > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    else if (s < -64'sh8000_0000) return 32'h8000_0000;
    else return v[31:0];
  endfunction

endpackage

// ----- design/vtlp_in_if.sv -----
// Input channel of the profile generator: valid/ready plus one item.
// Depends on nothing.
interface vtlp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] start_x;
  logic [31:0] start_y;
  logic [31:0] start_z;
  logic [30:0] target_height;
  logic [14:0] start_yaw;
  modport source(output valid, op, start_x, start_y, start_z, target_height, start_yaw,
                 input ready);
  modport sink(input valid, op, start_x, start_y, start_z, target_height, start_yaw,
               output ready);
endinterface

// ----- design/vtlp_out_if.sv -----
// Result channel of the profile generator: valid/ready plus one setpoint.
// Depends on nothing.
interface vtlp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sp_x;
  logic [31:0] sp_y;
  logic [31:0] sp_z;
  logic [31:0] sp_vz;
  logic [14:0] sp_yaw;
  logic        last;
  modport source(output valid, sp_x, sp_y, sp_z, sp_vz, sp_yaw, last, input ready);
  modport sink(input valid, sp_x, sp_y, sp_z, sp_vz, sp_yaw, last, output ready);
endinterface

// ----- design/vtlp_iter.sv -----
// Shared iterative unit: shift-add multiply (mod 2^64), restoring divide and
// digit-by-digit square root, all built around one 64-bit adder/subtractor.
// Depends on vtlp_pkg.
module vtlp_iter
  import vtlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  req_t        req,
  input  logic [63:0] opa,
  input  logic [63:0] opb,
  output logic        done,
  output logic [63:0] result
);

  iop_t        op_r;
  logic [63:0] x_r, y_r, acc_r, res_r;
  logic [6:0]  cnt_r;
  logic        busy_r, done_r;

  logic [63:0] add_a, add_b, shifted;
  logic        sub;
  logic [64:0] sum;

  always_comb begin
    shifted = acc_r;
    add_a   = acc_r;
    add_b   = x_r;
    sub     = 1'b0;
    unique case (op_r)
      IOP_MUL: begin
        add_a = acc_r;
        add_b = x_r;
      end
      IOP_DIV: begin
        shifted = {acc_r[62:0], x_r[63]};
        add_a   = shifted;
        add_b   = y_r;
        sub     = 1'b1;
      end
      IOP_SQRT: begin
        shifted = {acc_r[61:0], x_r[63:62]};
        add_a   = shifted;
        add_b   = {res_r[61:0], 2'b01};
        sub     = 1'b1;
      end
      default: begin
        add_a = acc_r;
      end
    endcase
    sum = {1'b0, add_a} + {1'b0, (sub ? ~add_b : add_b)} + {64'd0, sub};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= IOP_MUL;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        op_r   <= req.op;
        x_r    <= opa;
        y_r    <= opb;
        acc_r  <= '0;
        res_r  <= '0;
        busy_r <= 1'b1;
        unique case (req.op)
          IOP_DIV:  cnt_r <= DIV_STEPS;
          IOP_SQRT: cnt_r <= SQRT_STEPS;
          default:  cnt_r <= req.nbits;
        endcase
      end else if (busy_r) begin
        unique case (op_r)
          IOP_MUL: begin
            if (y_r[0]) acc_r <= sum[63:0];
            x_r <= {x_r[62:0], 1'b0};
            y_r <= {1'b0, y_r[63:1]};
          end
          IOP_DIV: begin
            acc_r <= sum[64] ? sum[63:0] : shifted;
            res_r <= {res_r[62:0], sum[64]};
            x_r   <= {x_r[62:0], 1'b0};
          end
          IOP_SQRT: begin
            acc_r <= sum[64] ? sum[63:0] : shifted;
            res_r <= {res_r[62:0], sum[64]};
            x_r   <= {x_r[61:0], 2'b00};
          end
          default: begin
            busy_r <= 1'b0;
          end
        endcase
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r <= 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = (op_r == IOP_MUL) ? acc_r : res_r;

endmodule

// ----- design/vertical_takeoff_land_profile.sv -----
// Top level of the vertical takeoff/landing setpoint generator.
// Depends on vtlp_pkg, vtlp_in_if, vtlp_out_if and vtlp_iter.
//
// Usage: items arrive on in_ch (valid/ready). Op takeoff or landing latches the
// start pose and height and plans the profile; it produces no result. Each
// tick while a profile runs produces one setpoint on out_ch; ticks while
// idle and op code 3 are taken and dropped. Registers step_time and
// vertical_accel are written through cfg_we/cfg_index/cfg_data and take
// effect at the next start.
// Arithmetic: all of it runs through one shared unit that retires one bit
// per cycle. A start runs a 64-step divide, a 32-step square root and a
// 64-step divide. A tick runs multiplies of 16, 16 and 36 steps in the
// acceleration phase, seven shift-add multiplies of 16 to 36 steps in the
// deceleration phase and none in the hold phase. A dropped item does not use
// the unit. in_ch.ready is low while an item is worked on.
// A finished setpoint sits in the output register; the next item is taken
// meanwhile, and a new result waits until the receiver takes the old one.
// Reset (rst_n, synchronous) returns the registers to defaults and the
// generator to idle with no pending result.
module vertical_takeoff_land_profile
  import vtlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  vtlp_in_if.sink     in_ch,
  vtlp_out_if.source  out_ch
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    JOB_START = 2'd0,
    JOB_ACC   = 2'd1,
    JOB_DEC   = 2'd2,
    JOB_HOLD  = 2'd3
  } job_t;

  state_t      state_r, state_nxt;
  job_t        job_r;
  mode_t       mode_r;
  logic [2:0]  step_r;
  logic        land_r;
  logic [15:0] step_time_r, accel_r, dt_r, acc_r;
  logic [31:0] hold_x_r, hold_y_r, half_r;
  logic [30:0] h_r;
  logic [14:0] yaw_r;
  logic [35:0] nr_r;
  logic [19:0] k_r, total_r;
  logic [63:0] tmp_r, t_r, vt_r, u_r, zt_r;

  req_t        req;
  logic [63:0] opa, opb, res;
  logic        done;

  vtlp_iter u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .opa    (opa),
    .opb    (opb),
    .done   (done),
    .result (res)
  );

  logic        accept;
  logic [36:0] k17, xdiff;
  logic [35:0] k16;
  logic        last_step;
  logic [63:0] nsat_w;
  logic [35:0] nsat;
  logic [20:0] tot21;
  logic [63:0] z_v, vz_v;
  logic        is_last;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign k17          = {k_r, 17'd0};
  assign k16          = {k_r, 16'd0};
  assign xdiff        = k17 - {1'b0, nr_r};
  assign nsat_w       = res;
  assign nsat         = (|nsat_w[63:36]) ? '1 : nsat_w[35:0];
  assign tot21        = {1'b0, nsat[35:16]} + {11'd0, HOLD_SAMPLES};
  assign is_last      = ({1'b0, k_r} + 21'd1) >= {1'b0, total_r};

  always_comb begin
    unique case (job_r)
      JOB_START: last_step = (step_r == 3'd2);
      JOB_ACC:   last_step = (step_r == 3'd2);
      default:   last_step = (step_r == 3'd6);
    endcase
  end

  // Operand selection for the shared unit.
  always_comb begin
    req.go    = (state_r == S_ISSUE);
    req.op    = IOP_MUL;
    req.nbits = 7'd16;
    opa       = '0;
    opb       = {48'd0, acc_r};
    unique case (job_r)
      JOB_START: begin
        unique case (step_r)
          3'd0: begin
            req.op = IOP_DIV;
            opa    = {1'b0, h_r, 32'd0};
          end
          3'd1: begin
            req.op = IOP_SQRT;
            opa    = tmp_r;
          end
          default: begin
            req.op = IOP_DIV;
            opa    = {15'd0, half_r, 17'd0};
            opb    = {48'd0, dt_r};
          end
        endcase
      end
      JOB_ACC: begin
        unique case (step_r)
          3'd0: begin
            opa = {44'd0, k_r};
            opb = {48'd0, dt_r};
          end
          3'd1: opa = t_r;
          default: begin
            opa       = vt_r;
            opb       = t_r;
            req.nbits = 7'd36;
          end
        endcase
      end
      default: begin
        unique case (step_r)
          3'd0: begin
            opa = {27'd0, xdiff};
            opb = {48'd0, dt_r};
          end
          3'd1: begin
            opa = {28'd0, nr_r};
            opb = {48'd0, dt_r};
          end
          3'd2: opa = tmp_r;
          3'd3: opa = {32'd0, half_r};
          3'd4: opa = t_r;
          3'd5: begin
            opa       = u_r;
            opb       = {32'd0, half_r};
            req.nbits = 7'd32;
          end
          default: begin
            opa       = vt_r + u_r;
            opb       = t_r;
            req.nbits = 7'd36;
          end
        endcase
      end
    endcase
  end

  // Setpoint values from the finished arithmetic.
  always_comb begin
    if (job_r == JOB_HOLD) begin
      z_v  = (mode_r == MODE_UP) ? {33'd0, h_r} : LAND_FLOOR;
      vz_v = '0;
    end else if (mode_r == MODE_UP) begin
      z_v  = zt_r;
      vz_v = vt_r;
    end else begin
      z_v  = {33'd0, h_r} - zt_r;
      vz_v = '0 - vt_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.op == OP_TAKEOFF || in_ch.op == OP_LAND) state_nxt = S_ISSUE;
          else if (in_ch.op == OP_TICK && mode_r != MODE_IDLE) begin
            state_nxt = ({1'b0, k16} < {1'b0, nr_r}) ? S_ISSUE : S_EMIT;
          end
        end
      end
      S_ISSUE: state_nxt = S_WAIT;
      S_WAIT: begin
        if (done) begin
          if (!last_step) state_nxt = S_ISSUE;
          else if (job_r == JOB_START) state_nxt = S_IDLE;
          else state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_ch.valid || out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= MODE_IDLE;
      job_r        <= JOB_HOLD;
      step_r       <= '0;
      step_time_r  <= STEP_TIME_RST;
      accel_r      <= ACCEL_RST;
      k_r          <= '0;
      total_r      <= '0;
      nr_r         <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_STEP_TIME) step_time_r <= cfg_data;
        else accel_r <= cfg_data;
      end
      if (state_r == S_EMIT && (!out_ch.valid || out_ch.ready)) out_ch.valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          step_r <= '0;
          if (accept) begin
            if (in_ch.op == OP_TAKEOFF || in_ch.op == OP_LAND) begin
              job_r    <= JOB_START;
              land_r   <= (in_ch.op == OP_LAND);
              hold_x_r <= in_ch.start_x;
              hold_y_r <= in_ch.start_y;
              dt_r     <= (step_time_r == '0) ? 16'd1 : step_time_r;
              acc_r    <= (accel_r == '0) ? 16'd1 : accel_r;
              if (in_ch.op == OP_TAKEOFF) begin
                h_r   <= in_ch.target_height;
                yaw_r <= in_ch.start_yaw;
              end else begin
                h_r   <= in_ch.start_z[31] ? '0 : in_ch.start_z[30:0];
                yaw_r <= '0;
              end
            end else if (in_ch.op == OP_TICK) begin
              if (k17 < {1'b0, nr_r}) job_r <= JOB_ACC;
              else if ({1'b0, k16} < {1'b0, nr_r}) job_r <= JOB_DEC;
              else job_r <= JOB_HOLD;
            end
          end
        end
        S_WAIT: begin
          if (done) begin
            step_r <= step_r + 3'd1;
            unique case (job_r)
              JOB_START: begin
                unique case (step_r)
                  3'd0: tmp_r  <= res;
                  3'd1: half_r <= res[31:0];
                  default: begin
                    nr_r    <= nsat;
                    total_r <= (tot21 > {1'b0, MAX_SAMPLES}) ? MAX_SAMPLES : tot21[19:0];
                    k_r     <= '0;
                    if (tot21 == '0) mode_r <= MODE_IDLE;
                    else mode_r <= land_r ? MODE_DOWN : MODE_UP;
                  end
                endcase
              end
              JOB_ACC: begin
                unique case (step_r)
                  3'd0:    t_r  <= res;
                  3'd1:    vt_r <= res >> 16;
                  default: zt_r <= res >> 17;
                endcase
              end
              default: begin
                unique case (step_r)
                  3'd0:    t_r  <= res >> 17;
                  3'd1:    tmp_r <= res >> 17;
                  3'd2:    vt_r <= res >> 16;
                  3'd3:    u_r  <= res >> 16;
                  3'd4:    vt_r <= vt_r - (res >> 16);
                  3'd5:    zt_r <= res >> 17;
                  default: zt_r <= zt_r + (res >> 17);
                endcase
              end
            endcase
          end
        end
        S_EMIT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.sp_x   <= hold_x_r;
            out_ch.sp_y   <= hold_y_r;
            out_ch.sp_z   <= sat32(z_v);
            out_ch.sp_vz  <= sat32(vz_v);
            out_ch.sp_yaw <= (job_r == JOB_ACC && mode_r == MODE_UP) ? yaw_r : '0;
            out_ch.last   <= is_last;
            k_r           <= k_r + 20'd1;
            if (is_last) mode_r <= MODE_IDLE;
          end
        end
        default: begin
          step_r <= step_r;
        end
      endcase
    end
  end

endmodule
